@@ rtl/core/refa_pkg.sv @@
// Shared types and constants of the ranging echo filtered average block.
`timescale 1ns / 1ps

package refa_pkg;

    // Field and state widths.
    localparam int DUR_W   = 20;
    localparam int X_W     = 23;
    localparam int MM_W    = 18;
    localparam int DIST_W  = 16;
    localparam int COUNT_W = 8;
    localparam int SUM_W   = 24;
    localparam int PROD_W  = 46;

    // Conversion to millimetres is floor(duration * 5 / 29).
    localparam int MM_NUM      = 5;
    localparam int MM_DEN      = 29;
    // The division by 29 is a multiplication by floor(2^28 / 29).
    localparam int RECIP_SHIFT = 28;
    localparam logic [23:0] RECIP_MUL = 24'd9256395;

    // Iterative divider for the series mean: one quotient bit a step.
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DISTANCE_MM = 1'b1;

    localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 8'd3;
    localparam logic [DIST_W-1:0]  MAX_DISTANCE_RESET = 16'd4000;

    // Current configuration as seen by the front and back parts.
    typedef struct packed {
        logic [COUNT_W-1:0] sample_count;
        logic [DIST_W-1:0]  max_distance_mm;
    } t_cfg;

    // One classified sample; the distance is zero when the sample is rejected.
    typedef struct packed {
        logic              good;
        logic [DIST_W-1:0] mm;
    } t_sample;

    // Status of the sample queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/core/ranging_echo_filtered_average_top.sv @@
// Top level of the ranging echo filtered average block.
// Path: the item that ends a series passes the two front stages (A and B), the queue, 24
// divider steps and one output load; with no good sample the divider steps are skipped.
// Throughput: one item a cycle while the queue has room; a series end holds the back part
// through the divider steps and the output load, or through the load alone if no sample is good.
// Reset: synchronous, active low; clears the series state, the queue and the output,
// and loads sample_count with 3 and max_distance_mm with 4000.
`timescale 1ns / 1ps

module ranging_echo_filtered_average_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [refa_pkg::DUR_W-1:0]       i_echo_duration_us,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [refa_pkg::DIST_W-1:0]      o_mean_mm,
    output logic                             o_no_good_sample,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [refa_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [refa_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [refa_pkg::COUNT_W-1:0] r_sample_count;
    logic [refa_pkg::DIST_W-1:0]  r_max_distance;

    refa_pkg::t_cfg    w_cfg;
    refa_pkg::t_sample w_push_data;
    refa_pkg::t_sample w_pop_data;
    refa_pkg::t_q_stat w_q_stat;
    logic              w_push;
    logic              w_pop;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= refa_pkg::SAMPLE_COUNT_RESET;
            r_max_distance <= refa_pkg::MAX_DISTANCE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                refa_pkg::CFG_SAMPLE_COUNT: begin
                    r_sample_count <= i_cfg_data[refa_pkg::COUNT_W-1:0];
                end
                refa_pkg::CFG_MAX_DISTANCE_MM: begin
                    r_max_distance <= i_cfg_data[refa_pkg::DIST_W-1:0];
                end
                default: begin
                    r_sample_count <= r_sample_count;
                end
            endcase
        end
    end

    assign w_cfg.sample_count    = r_sample_count;
    assign w_cfg.max_distance_mm = r_max_distance;

    refa_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_echo_duration_us (i_echo_duration_us),
        .i_cfg              (w_cfg),
        .i_q_stat           (w_q_stat),
        .o_push             (w_push),
        .o_sample           (w_push_data)
    );

    refa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_stat  (w_q_stat)
    );

    refa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_q_data         (w_pop_data),
        .i_q_stat         (w_q_stat),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mean_mm        (o_mean_mm),
        .o_no_good_sample (o_no_good_sample)
    );

endmodule

@@ rtl/core/refa_front.sv @@
// Front part: accepts echo items, converts them to millimetres and classifies them.
`timescale 1ns / 1ps

module refa_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [refa_pkg::DUR_W-1:0]   i_echo_duration_us,
    input  refa_pkg::t_cfg               i_cfg,
    input  refa_pkg::t_q_stat            i_q_stat,
    output logic                         o_push,
    output refa_pkg::t_sample            o_sample
);

    logic                        r_a_valid;
    logic [refa_pkg::X_W-1:0]    r_a_x;
    logic [refa_pkg::PROD_W-1:0] r_a_prod;
    logic                        r_b_valid;
    refa_pkg::t_sample           r_b_sample;

    logic [refa_pkg::X_W-1:0]    w_x;
    logic [refa_pkg::PROD_W-1:0] w_prod;
    logic [refa_pkg::MM_W-1:0]   w_q;
    logic [refa_pkg::X_W-1:0]    w_q_den;
    logic [refa_pkg::X_W-1:0]    w_rem;
    logic [refa_pkg::MM_W-1:0]   w_mm;
    logic                        w_good;
    logic                        w_push;
    logic                        w_b_free;
    logic                        w_a_move;
    logic                        w_accept;

    // Stage A: duration times five, then times the reciprocal of 29.
    assign w_x    = {1'b0, i_echo_duration_us, 2'b00}
                  + {3'b000, i_echo_duration_us};
    assign w_prod = {{(refa_pkg::PROD_W - refa_pkg::X_W){1'b0}}, w_x}
                  * {{(refa_pkg::PROD_W - 24){1'b0}}, refa_pkg::RECIP_MUL};

    // Stage B: the estimate is the quotient or one below; one compare fixes it.
    assign w_q     = r_a_prod[refa_pkg::RECIP_SHIFT +: refa_pkg::MM_W];
    assign w_q_den = {{(refa_pkg::X_W - refa_pkg::MM_W){1'b0}}, w_q}
                   * refa_pkg::X_W'(refa_pkg::MM_DEN);
    assign w_rem   = r_a_x - w_q_den;
    assign w_mm    = w_q + refa_pkg::MM_W'(w_rem >= refa_pkg::X_W'(refa_pkg::MM_DEN));
    assign w_good  = (w_mm != '0)
                  && (w_mm < {{(refa_pkg::MM_W - refa_pkg::DIST_W){1'b0}},
                              i_cfg.max_distance_mm});

    // Handshake through the two stages into the queue.
    assign w_push     = r_b_valid & ~i_q_stat.full;
    assign w_b_free   = ~r_b_valid | w_push;
    assign w_a_move   = r_a_valid & w_b_free;
    assign o_in_ready = ~r_a_valid | w_b_free;
    assign w_accept   = i_in_valid & o_in_ready;

    assign o_push   = w_push;
    assign o_sample = r_b_sample;

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_a_move) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_move) begin
                r_b_valid <= 1'b1;
            end else if (w_push) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_x    <= w_x;
            r_a_prod <= w_prod;
        end
        if (w_a_move) begin
            r_b_sample.good <= w_good;
            r_b_sample.mm   <= w_good ? w_mm[refa_pkg::DIST_W-1:0] : '0;
        end
    end

endmodule

@@ rtl/core/refa_queue.sv @@
// Short queue of classified samples between the front and back parts.
`timescale 1ns / 1ps

module refa_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  refa_pkg::t_sample i_data,
    input  logic              i_pop,
    output refa_pkg::t_sample o_data,
    output refa_pkg::t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    refa_pkg::t_sample r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign w_do_push    = i_push & ~o_stat.full;
    assign w_do_pop     = i_pop & ~o_stat.empty;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/refa_back.sv @@
// Back part: accumulates good samples, divides at the end of a series, holds the result.
`timescale 1ns / 1ps

module refa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  refa_pkg::t_cfg              i_cfg,
    input  refa_pkg::t_sample           i_q_data,
    input  refa_pkg::t_q_stat           i_q_stat,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [refa_pkg::DIST_W-1:0] o_mean_mm,
    output logic                        o_no_good_sample
);

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_DIV,
        ST_EMIT
    } t_state;

    t_state                         r_state;
    logic [refa_pkg::COUNT_W-1:0]   r_seen;
    logic [refa_pkg::SUM_W-1:0]     r_sum;
    logic [refa_pkg::COUNT_W-1:0]   r_total;
    logic [refa_pkg::SUM_W-1:0]     r_work;
    logic [refa_pkg::COUNT_W-1:0]   r_div;
    logic [refa_pkg::COUNT_W-1:0]   r_rem;
    logic [refa_pkg::STEP_W-1:0]    r_step;
    logic                           r_none;
    logic                           r_out_valid;
    logic [refa_pkg::DIST_W-1:0]    r_out_dist;
    logic                           r_out_none;

    logic [refa_pkg::SUM_W-1:0]     n_sum;
    logic [refa_pkg::COUNT_W-1:0]   n_total;
    logic [refa_pkg::COUNT_W-1:0]   n_seen;
    logic [refa_pkg::COUNT_W-1:0]   w_need;
    logic                           w_end;
    logic [refa_pkg::COUNT_W:0]     w_rem_sh;
    logic                           w_ge;
    logic [refa_pkg::COUNT_W:0]     n_rem;

    // Series bookkeeping for the sample at the head of the queue.
    assign o_pop   = (r_state == ST_TAKE) && !i_q_stat.empty;
    assign n_sum   = r_sum + {{(refa_pkg::SUM_W - refa_pkg::DIST_W){1'b0}}, i_q_data.mm};
    assign n_total = r_total + refa_pkg::COUNT_W'(i_q_data.good);
    assign n_seen  = r_seen + 1'b1;
    assign w_need  = (i_cfg.sample_count == '0) ? refa_pkg::COUNT_W'(1)
                                                : i_cfg.sample_count;
    assign w_end   = (n_seen == '0) || (n_seen >= w_need);

    // One restoring division step.
    assign w_rem_sh = {r_rem, r_work[refa_pkg::SUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});
    assign n_rem    = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    assign o_out_valid      = r_out_valid;
    assign o_mean_mm        = r_out_dist;
    assign o_no_good_sample = r_out_none;

    // Sequencer, series state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_TAKE;
            r_seen      <= '0;
            r_sum       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Outside the emit state an accepted result simply empties the output register.
            if (r_out_valid && i_out_ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_TAKE: begin
                    if (o_pop) begin
                        if (w_end) begin
                            r_seen  <= '0;
                            r_sum   <= '0;
                            r_total <= '0;
                            r_work  <= n_sum;
                            r_div   <= n_total;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_none  <= (n_total == '0);
                            r_state <= (n_total == '0) ? ST_EMIT : ST_DIV;
                        end else begin
                            r_seen  <= n_seen;
                            r_sum   <= n_sum;
                            r_total <= n_total;
                        end
                    end
                end
                ST_DIV: begin
                    r_rem  <= n_rem[refa_pkg::COUNT_W-1:0];
                    r_work <= {r_work[refa_pkg::SUM_W-2:0], w_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == refa_pkg::STEP_W'(refa_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_dist  <= r_work[refa_pkg::DIST_W-1:0];
                        r_out_none  <= r_none;
                        r_state     <= ST_TAKE;
                    end
                end
                default: begin
                    r_state <= ST_TAKE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/refa_checker.sv @@
// Port-level checker of the ranging echo filtered average block and its bind.
`timescale 1ns / 1ps

module refa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [refa_pkg::DIST_W-1:0] o_mean_mm,
    input logic                        o_no_good_sample
);

    // A stalled result keeps its item.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_mean_mm) && $stable(o_no_good_sample))
        else $error("result item changed while stalled");

    // A series with no good sample reports a zero distance.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_good_sample |-> o_mean_mm == '0)
        else $error("rejected series with nonzero distance");

    // A mean of good samples lies strictly between zero and the largest limit.
    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_no_good_sample |->
            o_mean_mm != '0 && o_mean_mm != '1)
        else $error("mean of good samples out of range");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

endmodule

bind ranging_echo_filtered_average_top refa_checker u_refa_checker (.*);

@@ tb/sv/tb_ranging_echo_filtered_average_top.sv @@
// Self-checking testbench of the ranging echo filtered average block.
`timescale 1ns / 1ps

module tb_ranging_echo_filtered_average_top;

    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 850;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PRESSURE_LEN  = 60;
    localparam int DUR_MAX       = 1000000;

    typedef struct packed {
        logic [refa_pkg::DIST_W-1:0] mean_mm;
        logic                        no_good_sample;
    } t_range_result;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ECHO,
        ROW_ECHO_TYPED
    } t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic [refa_pkg::CFG_INDEX_W-1:0] index;
        logic [refa_pkg::CFG_DATA_W-1:0]  data;
        logic [refa_pkg::DUR_W-1:0]       duration;
        t_range_result                    typed;
    } t_stim_row;

    logic                             i_clk              = 1'b0;
    logic                             i_rst_n            = 1'b0;
    logic                             i_in_valid         = 1'b0;
    logic                             o_in_ready;
    logic [refa_pkg::DUR_W-1:0]       i_echo_duration_us = '0;
    logic                             o_out_valid;
    logic                             i_out_ready        = 1'b0;
    logic [refa_pkg::DIST_W-1:0]      o_mean_mm;
    logic                             o_no_good_sample;
    logic                             i_cfg_valid        = 1'b0;
    logic                             o_cfg_ready;
    logic [refa_pkg::CFG_INDEX_W-1:0] i_cfg_index        = '0;
    logic [refa_pkg::CFG_DATA_W-1:0]  i_cfg_data         = '0;

    // Predictor copy of the configuration and of the series state.
    logic [refa_pkg::COUNT_W-1:0] cur_count   = refa_pkg::SAMPLE_COUNT_RESET;
    logic [refa_pkg::DIST_W-1:0]  cur_max     = refa_pkg::MAX_DISTANCE_RESET;
    logic [refa_pkg::COUNT_W-1:0] series_seen = '0;
    logic [refa_pkg::SUM_W-1:0]   series_sum  = '0;
    logic [refa_pkg::COUNT_W-1:0] series_good = '0;

    t_range_result pending_ranges[$];
    int            mismatches  = 0;
    int            cycle_count = 0;
    bit            no_gaps     = 1'b0;
    bit            stall_req   = 1'b0;

    ranging_echo_filtered_average_top i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_echo_duration_us (i_echo_duration_us),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_mean_mm          (o_mean_mm),
        .o_no_good_sample   (o_no_good_sample),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // Free-running clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Accumulates one echo into the series and says whether it closes the series.
    function automatic bit predict_series_end(input logic [refa_pkg::DUR_W-1:0] dur,
                                              output t_range_result res);
        logic [31:0]                  mm;
        logic [refa_pkg::COUNT_W-1:0] need;
        mm   = (32'(dur) * refa_pkg::MM_NUM) / refa_pkg::MM_DEN;
        need = (cur_count == '0) ? refa_pkg::COUNT_W'(1) : cur_count;
        res  = '0;
        if (mm > 32'd0 && mm < 32'(cur_max)) begin
            series_sum  = series_sum + refa_pkg::SUM_W'(mm);
            series_good = series_good + refa_pkg::COUNT_W'(1);
        end
        series_seen = series_seen + refa_pkg::COUNT_W'(1);
        if (series_seen != '0 && series_seen < need) begin
            return 1'b0;
        end
        if (series_good == '0) begin
            res.mean_mm        = '0;
            res.no_good_sample = 1'b1;
        end else begin
            res.mean_mm        = refa_pkg::DIST_W'(series_sum
                                                   / refa_pkg::SUM_W'(series_good));
            res.no_good_sample = 1'b0;
        end
        series_seen = '0;
        series_sum  = '0;
        series_good = '0;
        return 1'b1;
    endfunction

    // Sender gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int unsigned r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        if (r < 98) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 60));
    endfunction

    // Random echo duration, weighted towards the good range and its upper limit.
    function automatic logic [refa_pkg::DUR_W-1:0] random_echo(input bit heavy);
        int unsigned limit_dur;
        int unsigned r;
        int unsigned hi;
        int          d;
        // Smallest duration whose distance reaches the current limit.
        limit_dur = (32'(cur_max) * refa_pkg::MM_DEN + refa_pkg::MM_NUM - 1)
                  / refa_pkg::MM_NUM;
        r = $urandom_range(0, 99);
        if (heavy) begin
            d = (r < 90) ? int'($urandom_range(370000, 380098))
                         : int'($urandom_range(0, DUR_MAX));
        end else if (r < 10) begin
            d = 0;
        end else if (r < 55) begin
            hi = (limit_dur + 10 > DUR_MAX) ? DUR_MAX : limit_dur + 10;
            d  = int'($urandom_range(0, hi));
        end else if (r < 70) begin
            d = int'(limit_dur) + int'($urandom_range(0, 12)) - 6;
        end else if (r < 80) begin
            d = int'($urandom_range(380080, 380110));
        end else if (r < 88) begin
            d = int'($urandom_range(0, 12));
        end else begin
            d = int'($urandom_range(0, DUR_MAX));
        end
        if (d < 0) d = 0;
        if (d > DUR_MAX) d = DUR_MAX;
        return refa_pkg::DUR_W'(d);
    endfunction

    function automatic t_stim_row cfg_row(input logic [refa_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [refa_pkg::CFG_DATA_W-1:0] d);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.index = idx;
        row.data  = d;
        return row;
    endfunction

    function automatic t_stim_row echo_row(input logic [refa_pkg::DUR_W-1:0] dur);
        t_stim_row row;
        row          = '0;
        row.kind     = ROW_ECHO;
        row.duration = dur;
        return row;
    endfunction

    function automatic t_stim_row typed_row(input logic [refa_pkg::DUR_W-1:0] dur,
                                            input logic [refa_pkg::DIST_W-1:0] mean,
                                            input logic flag);
        t_stim_row row;
        row                      = '0;
        row.kind                 = ROW_ECHO_TYPED;
        row.duration             = dur;
        row.typed.mean_mm        = mean;
        row.typed.no_good_sample = flag;
        return row;
    endfunction

    // Offers one echo item and records the result it is due to close.
    task automatic send_echo(input logic [refa_pkg::DUR_W-1:0] dur, input bit use_typed,
                             input t_range_result typed_res);
        int            gap;
        t_range_result res;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid         = 1'b1;
        i_echo_duration_us = dur;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_series_end(dur, res)) begin
            pending_ranges.push_back(use_typed ? typed_res : res);
        end
    endtask

    // Register write, issued only once the block has drained.
    task automatic write_register(input logic [refa_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [refa_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = d;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == refa_pkg::CFG_SAMPLE_COUNT) begin
            cur_count = d[refa_pkg::COUNT_W-1:0];
        end else begin
            cur_max = d;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Result checker: each accepted item is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_ranges
        t_range_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_ranges.size() == 0) begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected result: expected none, actual mean %0d flag %0b",
                         $time, o_mean_mm, o_no_good_sample);
            end else begin
                exp_res = pending_ranges.pop_front();
                if (o_mean_mm !== exp_res.mean_mm) begin
                    mismatches = mismatches + 1;
                    $display("%0t: mean_mm: expected %0d, actual %0d",
                             $time, exp_res.mean_mm, o_mean_mm);
                end
                if (o_no_good_sample !== exp_res.no_good_sample) begin
                    mismatches = mismatches + 1;
                    $display("%0t: no_good_sample: expected %0b, actual %0b",
                             $time, exp_res.no_good_sample, o_no_good_sample);
                end
            end
        end
    end

    // Receiver: random ready stretches, plus one long hold-off on request.
    initial begin : drive_result_ready
        int          run_left;
        bit          hold_done;
        int unsigned r;
        run_left  = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req && !hold_done) begin
                hold_done   = 1'b1;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                run_left = 0;
            end else if (run_left > 0) begin
                run_left = run_left - 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    i_out_ready = 1'b0;
                    run_left    = (r < 27) ? int'($urandom_range(0, 2))
                                           : int'($urandom_range(15, 60));
                end else begin
                    i_out_ready = 1'b1;
                    run_left    = (r > 90) ? int'($urandom_range(50, 200))
                                           : int'($urandom_range(0, 15));
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin : run_stimulus
        t_stim_row                    dir_tab[$];
        int                           items_sent;
        int                           phase;
        int                           n;
        int unsigned                  r;
        int unsigned                  which;
        bit                           heavy;
        logic [refa_pkg::COUNT_W-1:0] new_count;
        logic [refa_pkg::DIST_W-1:0]  new_max;
        logic [refa_pkg::COUNT_W-1:0] upper;
        logic [refa_pkg::COUNT_W-1:0] need;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values first, then the extremes, the zero cases and a mid-series count drop.
        dir_tab = '{
            echo_row(20'd0),
            echo_row(20'd0),
            typed_row(20'd0, 16'd0, 1'b1),
            echo_row(20'd6),
            echo_row(20'd23195),
            echo_row(20'd23200),
            cfg_row(refa_pkg::CFG_SAMPLE_COUNT, 16'd1),
            typed_row(20'd1000000, 16'd0, 1'b1),
            typed_row(20'd23195, 16'd3999, 1'b0),
            typed_row(20'd23200, 16'd0, 1'b1),
            typed_row(20'd6, 16'd1, 1'b0),
            cfg_row(refa_pkg::CFG_MAX_DISTANCE_MM, 16'd65535),
            typed_row(20'd380098, 16'd65534, 1'b0),
            typed_row(20'd380104, 16'd0, 1'b1),
            cfg_row(refa_pkg::CFG_SAMPLE_COUNT, 16'd0),
            typed_row(20'd5, 16'd0, 1'b1),
            typed_row(20'd29, 16'd5, 1'b0),
            cfg_row(refa_pkg::CFG_MAX_DISTANCE_MM, 16'd0),
            typed_row(20'd600, 16'd0, 1'b1),
            cfg_row(refa_pkg::CFG_MAX_DISTANCE_MM, 16'd4000),
            cfg_row(refa_pkg::CFG_SAMPLE_COUNT, 16'hA505),
            echo_row(20'd100),
            echo_row(20'd200),
            echo_row(20'd300),
            cfg_row(refa_pkg::CFG_SAMPLE_COUNT, 16'd2),
            echo_row(20'd400)
        };
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_register(dir_tab[i].index, dir_tab[i].data);
            end else begin
                send_echo(dir_tab[i].duration, dir_tab[i].kind == ROW_ECHO_TYPED,
                          dir_tab[i].typed);
            end
        end

        // Random phases, each under a fresh setting of the registers.
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            phase = phase + 1;
            heavy = 1'b0;
            if (phase == 3) begin
                // One result per item with the receiver held off, so the queue backs up.
                write_register(refa_pkg::CFG_SAMPLE_COUNT, 16'd1);
                no_gaps   = 1'b1;
                stall_req = 1'b1;
                for (int k = 0; k < PRESSURE_LEN; k++) begin
                    send_echo(random_echo(1'b0), 1'b0, '0);
                end
                items_sent = items_sent + PRESSURE_LEN;
                continue;
            end

            r = $urandom_range(0, 99);
            if (r < 8)       new_count = '0;
            else if (r < 14) new_count = 8'd255;
            else if (r < 20) new_count = refa_pkg::COUNT_W'($urandom_range(100, 254));
            else             new_count = refa_pkg::COUNT_W'($urandom_range(1, 8));
            r = $urandom_range(0, 99);
            if (r < 8)       new_max = '0;
            else if (r < 16) new_max = 16'd1;
            else if (r < 26) new_max = 16'd65535;
            else if (r < 40) new_max = 16'd4000;
            else             new_max = refa_pkg::DIST_W'($urandom_range(1, 65535));
            // Long series of near-limit good samples stress the sum width.
            if (new_count == 8'd255 && $urandom_range(0, 1) == 1) begin
                heavy   = 1'b1;
                new_max = 16'd65535;
            end
            upper = ($urandom_range(0, 1) == 1) ? refa_pkg::COUNT_W'($urandom_range(0, 255))
                                                : '0;
            which = heavy ? 2 : $urandom_range(0, 4);
            if (which != 1) write_register(refa_pkg::CFG_SAMPLE_COUNT, {upper, new_count});
            if (which != 0) write_register(refa_pkg::CFG_MAX_DISTANCE_MM, new_max);

            no_gaps = ($urandom_range(0, 3) == 0);
            need    = (cur_count == '0) ? refa_pkg::COUNT_W'(1) : cur_count;
            if (need >= 8'd100) begin
                n = int'(need) + int'($urandom_range(0, 3));
            end else begin
                n = int'(need) * int'($urandom_range(1, 6)) + int'($urandom_range(0, 2));
            end
            for (int k = 0; k < n && items_sent < RANDOM_ITEMS; k++) begin
                send_echo(random_echo(heavy), 1'b0, '0);
                items_sent = items_sent + 1;
            end
        end

        // Drain and let the block settle before the verdict.
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_ranges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ ranging_echo_filtered_average_top.f @@
rtl/core/refa_pkg.sv
rtl/core/refa_front.sv
rtl/core/refa_queue.sv
rtl/core/refa_back.sv
rtl/core/ranging_echo_filtered_average_top.sv
rtl/core/refa_checker.sv
tb/sv/tb_ranging_echo_filtered_average_top.sv
